// File: sv/aaop_pkg.sv
package aaop_pkg;

    localparam int BLOCK_BYTES  = 1024;
    localparam int CAP_FRAMES   = BLOCK_BYTES / 4;
    localparam int FRAMES_W     = 9;
    localparam int MAXP_W       = 11;
    localparam int FB_W         = 6;
    localparam int DIV_CNT_W    = 4;
    localparam int RATE_W       = 32;
    localparam int SEED_W       = 24;
    localparam int APB_ADDR_W   = 5;

    localparam logic [RATE_W-1:0]   MAX_RATE     = RATE_W'(CAP_FRAMES) << 16;
    localparam logic [RATE_W-1:0]   ZERO_SEED    = RATE_W'(6) << 16;
    localparam logic [SEED_W-1:0]   SEED_RESET   = SEED_W'(393216);
    localparam logic [MAXP_W-1:0]   MAXP_RESET   = MAXP_W'(1024);
    localparam logic [MAXP_W-1:0]   CAP_N        = MAXP_W'(CAP_FRAMES);

    localparam logic [2:0] REG_SUBSLOT  = 3'd0;
    localparam logic [2:0] REG_CHANNELS = 3'd1;
    localparam logic [2:0] REG_ASYNC    = 3'd2;
    localparam logic [2:0] REG_MAXP     = 3'd3;
    localparam logic [2:0] REG_SEED     = 3'd4;

    typedef enum logic [1:0] {
        OP_FEEDBACK = 2'd0,
        OP_PACKET   = 2'd1,
        OP_SAMPLE   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_RATE   = 2'd0,
        KIND_PACKET = 2'd1,
        KIND_BYTE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]        subslot;
        logic [3:0]        channels;
        logic [FB_W-1:0]   frame_bytes;
        logic              async_mode;
        logic [MAXP_W-1:0] maxp;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [SEED_W-1:0] value;
    } t_seed_wr;

    typedef struct packed {
        logic load;
        logic pkt_fin;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic last;
    } t_stat;

    // byte i of a subslot of s bytes carrying a 16-bit sample, low end zero padded
    function automatic logic [7:0] slot_byte(logic [2:0] s, logic [1:0] i, logic [15:0] v);
        logic [7:0] b;
        b = 8'd0;
        case (s)
            3'd1: b = v[15:8];
            3'd2: b = (i == 2'd0) ? v[7:0] : v[15:8];
            3'd3: begin
                if (i == 2'd1) b = v[7:0];
                else if (i == 2'd2) b = v[15:8];
            end
            default: begin
                if (i == 2'd2) b = v[7:0];
                else if (i == 2'd3) b = v[15:8];
            end
        endcase
        return b;
    endfunction

endpackage

// File: sv/aaop_if.sv
interface aaop_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic        feedback_ok;
    logic [2:0]  feedback_len;
    logic [31:0] feedback_word;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (
        output valid, opcode, feedback_ok, feedback_len, feedback_word,
               left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, opcode, feedback_ok, feedback_len, feedback_word,
               left_sample, right_sample,
        output ready
    );
endinterface

interface aaop_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] rate_value;
    logic [8:0]  frame_count;
    logic [10:0] packet_bytes;
    logic [7:0]  byte_value;
    logic [15:0] peak_level;
    logic        last;

    modport source (
        output valid, kind, rate_value, frame_count, packet_bytes, byte_value,
               peak_level, last,
        input  ready
    );
    modport sink (
        input  valid, kind, rate_value, frame_count, packet_bytes, byte_value,
               peak_level, last,
        output ready
    );
endinterface

// File: sv/aaop_cfg.sv
module aaop_cfg
    import aaop_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    output t_seed_wr              o_seed_wr
);

    logic [2:0]        r_subslot;
    logic [3:0]        r_channels;
    logic              r_async;
    logic [MAXP_W-1:0] r_maxp;
    logic [SEED_W-1:0] r_seed;
    logic              wr_en;
    logic [2:0]        idx;
    logic [2:0]        s_eff;
    logic [3:0]        c_eff;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subslot  <= 3'd2;
            r_channels <= 4'd2;
            r_async    <= 1'b0;
            r_maxp     <= MAXP_RESET;
            r_seed     <= SEED_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_SUBSLOT:  r_subslot  <= pwdata[2:0];
                REG_CHANNELS: r_channels <= pwdata[3:0];
                REG_ASYNC:    r_async    <= pwdata[0];
                REG_MAXP:     r_maxp     <= pwdata[MAXP_W-1:0];
                REG_SEED:     r_seed     <= pwdata[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (idx)
            REG_SUBSLOT:  prdata = 32'(r_subslot);
            REG_CHANNELS: prdata = 32'(r_channels);
            REG_ASYNC:    prdata = 32'(r_async);
            REG_MAXP:     prdata = 32'(r_maxp);
            REG_SEED:     prdata = 32'(r_seed);
            default:      prdata = 32'd0;
        endcase
    end

    // zero counts as one, anything above the limit as the limit
    always_comb begin
        s_eff = r_subslot;
        if (r_subslot == 3'd0) s_eff = 3'd1;
        else if (r_subslot > 3'd4) s_eff = 3'd4;
        c_eff = r_channels;
        if (r_channels == 4'd0) c_eff = 4'd1;
        else if (r_channels > 4'd8) c_eff = 4'd8;
    end

    assign o_cfg.subslot     = s_eff;
    assign o_cfg.channels    = c_eff;
    assign o_cfg.frame_bytes = FB_W'(s_eff) * FB_W'(c_eff);
    assign o_cfg.async_mode  = r_async;
    assign o_cfg.maxp        = (32'(r_maxp) > 32'(BLOCK_BYTES)) ? MAXP_W'(BLOCK_BYTES)
                                                                : r_maxp;

    assign o_seed_wr.load  = wr_en && (idx == REG_SEED);
    assign o_seed_wr.value = pwdata[SEED_W-1:0];

endmodule

// File: sv/aaop_div.sv
module aaop_div
    import aaop_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAXP_W-1:0] i_dividend,
    input  logic [FB_W-1:0]   i_divisor,
    output logic              o_busy,
    output logic [MAXP_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FB_W-1:0]      r_rem;
    logic [MAXP_W-1:0]    r_quo;
    logic [FB_W-1:0]      r_div;
    logic [FB_W+1:0]      diff;
    logic [FB_W:0]        shifted;

    // one quotient bit per cycle, restoring
    assign shifted = {r_rem, r_quo[MAXP_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(MAXP_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!diff[FB_W+1]) begin
                r_rem <= diff[FB_W-1:0];
                r_quo <= {r_quo[MAXP_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[FB_W-1:0];
                r_quo <= {r_quo[MAXP_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: sv/aaop_ctrl.sv
module aaop_ctrl
    import aaop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_PACKET:   n_state = ST_DIV;
                        OP_FEEDBACK: n_state = ST_OUT;
                        OP_SAMPLE:   n_state = ST_OUT;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.pkt_fin = 1'b1;
                    n_state       = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) n_state = ST_IDLE;
                    else             o_cmd.step = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: sv/aaop_dp.sv
module aaop_dp
    import aaop_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_seed_wr      i_seed_wr,
    input  t_cmd          i_cmd,
    input  logic [1:0]    i_opcode,
    input  logic          i_feedback_ok,
    input  logic [2:0]    i_feedback_len,
    input  logic [31:0]   i_feedback_word,
    input  logic [15:0]   i_left_sample,
    input  logic [15:0]   i_right_sample,
    output t_stat         o_stat,
    output logic [1:0]    o_kind,
    output logic [31:0]   o_rate_value,
    output logic [8:0]    o_frame_count,
    output logic [10:0]   o_packet_bytes,
    output logic [7:0]    o_byte_value,
    output logic [15:0]   o_peak_level,
    output logic          o_last
);

    logic [RATE_W-1:0]   r_rate;
    logic [15:0]         r_frac;
    logic [15:0]         r_peak;
    t_kind               r_kind;
    logic [MAXP_W-1:0]   r_na;
    logic [FRAMES_W-1:0] r_frames;
    logic [MAXP_W-1:0]   r_bytes;
    logic [15:0]         r_left;
    logic [15:0]         r_right;
    logic [2:0]          r_ch;
    logic [1:0]          r_slot;

    logic [RATE_W-1:0]   fb_val;
    logic                fb_take;
    logic [RATE_W:0]     sum;
    logic [16:0]         sum_int;
    logic [15:0]         mag;
    logic                div_start;
    logic                div_busy;
    logic [MAXP_W-1:0]   quo;
    logic [MAXP_W-1:0]   n_frames;
    logic [MAXP_W-1:0]   n_bytes;
    logic                slot_end;
    logic                frame_end;

    assign fb_val  = (i_feedback_len >= 3'd4) ? i_feedback_word
                                              : {i_feedback_word[23:0], 2'b00} ;
    assign fb_take = i_feedback_ok && (i_feedback_len >= 3'd3)
                     && (fb_val != '0) && (fb_val < MAX_RATE);

    assign sum     = {{(RATE_W-15){1'b0}}, r_frac} + {1'b0, r_rate};
    assign sum_int = sum[32:16];

    // -32768 maps to 32768, still fits 16 bits
    assign mag = i_left_sample[15] ? (~i_left_sample + 16'd1) : i_left_sample;

    assign div_start = i_cmd.load && (i_opcode == OP_PACKET);

    aaop_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cfg.maxp),
        .i_divisor  (i_cfg.frame_bytes),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // more frames than fit the packet fall back to max packet / frame bytes
    always_comb begin
        logic [MAXP_W+FB_W-1:0] prod;
        n_frames = r_na;
        if (quo < r_na) n_frames = quo;
        prod    = n_frames * i_cfg.frame_bytes;
        n_bytes = (n_frames == '0) ? MAXP_W'(i_cfg.frame_bytes) : prod[MAXP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_W'(SEED_RESET);
            r_frac <= '0;
            r_peak <= '0;
        end else if (i_seed_wr.load) begin
            r_rate <= (i_seed_wr.value == '0) ? ZERO_SEED : RATE_W'(i_seed_wr.value);
        end else if (i_cmd.load) begin
            case (i_opcode)
                OP_FEEDBACK: if (fb_take) r_rate <= fb_val;
                OP_PACKET:   if (i_cfg.async_mode) r_frac <= sum[15:0];
                OP_SAMPLE:   if (mag > r_peak) r_peak <= mag;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frames <= '0;
            r_bytes  <= '0;
            r_left   <= i_left_sample;
            r_right  <= i_right_sample;
            r_ch     <= '0;
            r_slot   <= '0;
            if (!i_cfg.async_mode || (32'(sum_int) > 32'(CAP_N))) r_na <= CAP_N;
            else                                                    r_na <= sum_int[MAXP_W-1:0];
            case (i_opcode)
                OP_FEEDBACK: r_kind <= KIND_RATE;
                OP_PACKET:   r_kind <= KIND_PACKET;
                default:     r_kind <= KIND_BYTE;
            endcase
        end else if (i_cmd.pkt_fin) begin
            r_frames <= n_frames[FRAMES_W-1:0];
            r_bytes  <= n_bytes;
        end else if (i_cmd.step) begin
            if (slot_end) begin
                r_slot <= '0;
                r_ch   <= r_ch + 1'b1;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    assign slot_end  = ({1'b0, r_slot} == i_cfg.subslot - 3'd1);
    assign frame_end = slot_end && ({1'b0, r_ch} == i_cfg.channels - 4'd1);

    always_comb begin
        o_byte_value = 8'd0;
        if (r_kind == KIND_BYTE) begin
            if (r_ch == 3'd0)      o_byte_value = slot_byte(i_cfg.subslot, r_slot, r_left);
            else if (r_ch == 3'd1) o_byte_value = slot_byte(i_cfg.subslot, r_slot, r_right);
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.last     = o_last;

    assign o_last         = (r_kind != KIND_BYTE) || frame_end;
    assign o_kind         = r_kind;
    assign o_rate_value   = r_rate;
    assign o_frame_count  = r_frames;
    assign o_packet_bytes = r_bytes;
    assign o_peak_level   = r_peak;

endmodule

// File: sv/async_audio_out_packetizer.sv
// Isochronous audio OUT packetizer. Items are taken one at a time. A feedback
// word (opcode 0) gives one rate report. A packet request (opcode 1) runs the
// 11-step bit-serial divider that works out max packet / frame bytes, and
// gives one packet-size word. A sample pair (opcode 2) gives one word per
// packed byte, subslot_bytes * channel_count words at one per cycle while
// ready is high. Opcode 3 is dropped. Result words hold while ready is low;
// the next item is taken after the last word of the current one.
// Configuration goes through the APB port at byte address 4*i and must only
// be written while the block is idle (the block does not enforce this);
// writing seed_rate also reloads the current rate (zero loads 6.0 frames).
module async_audio_out_packetizer
    import aaop_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aaop_in_if.sink               i_item,
    aaop_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg     cfg;
    t_seed_wr seed_wr;
    t_cmd     cmd;
    t_stat    stat;
    logic     in_ready;
    logic     out_valid;

    aaop_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_seed_wr (seed_wr)
    );

    aaop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_opcode    (i_item.opcode),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    aaop_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_seed_wr       (seed_wr),
        .i_cmd           (cmd),
        .i_opcode        (i_item.opcode),
        .i_feedback_ok   (i_item.feedback_ok),
        .i_feedback_len  (i_item.feedback_len),
        .i_feedback_word (i_item.feedback_word),
        .i_left_sample   (i_item.left_sample),
        .i_right_sample  (i_item.right_sample),
        .o_stat          (stat),
        .o_kind          (o_result.kind),
        .o_rate_value    (o_result.rate_value),
        .o_frame_count   (o_result.frame_count),
        .o_packet_bytes  (o_result.packet_bytes),
        .o_byte_value    (o_result.byte_value),
        .o_peak_level    (o_result.peak_level),
        .o_last          (o_result.last)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

endmodule

// File: tb/testbench.sv
module testbench;
    import aaop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SEGMENTS      = 9;
    localparam int SEG_ITEMS     = 40;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {CHK_NONE, CHK_RATE, CHK_PKT, CHK_PEAK} t_check;
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one line of stimulus; for ROW_CFG the register value rides in word
    typedef struct packed {
        t_row_kind          kind;
        logic [1:0]         op;
        logic               ok;
        logic [2:0]         len;
        logic [31:0]        word;
        logic signed [15:0] left;
        logic signed [15:0] right;
        t_check             chk;
        logic [31:0]        typed_a;
        logic [10:0]        typed_b;
        logic [2:0]         cfg_reg;
    } t_row;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] rate_value;
        logic [8:0]  frame_count;
        logic [10:0] packet_bytes;
        logic [7:0]  byte_value;
        logic [15:0] peak_level;
        logic        last;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    aaop_in_if  in_ch();
    aaop_out_if out_ch();

    async_audio_out_packetizer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the block's registers and running state
    logic [2:0]  cfg_subslot  = 3'd2;
    logic [3:0]  cfg_channels = 4'd2;
    logic        cfg_async    = 1'b0;
    logic [10:0] cfg_maxp     = MAXP_RESET;
    logic [23:0] cfg_seed     = SEED_RESET;
    logic [15:0] frac_acc     = 16'd0;
    logic [31:0] rate_q16     = {8'd0, SEED_RESET};
    logic [15:0] peak_abs     = 16'd0;

    t_word expected_words[$];

    int err_count    = 0;
    int words_done   = 0;
    int items_sent   = 0;
    int cfg_writes   = 0;
    int cycles       = 0;
    int tx_idle_pct  = 6;
    int rx_idle_pct  = 66;

    t_row plan[$];
    t_row row;
    int   counted;

    function automatic string word_text(t_word w);
        return $sformatf("kind=%0d rate=%h frames=%0d bytes=%0d byte=%h peak=%0d last=%b",
                         w.kind, w.rate_value, w.frame_count, w.packet_bytes,
                         w.byte_value, w.peak_level, w.last);
    endfunction

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // byte i of a subslot of s bytes: high byte at the top, low byte just below it
    function automatic logic [7:0] subslot_byte(int s, int i, logic [15:0] v);
        int hi_pos;
        hi_pos = (s >= 4) ? 3 : s - 1;
        if (i == hi_pos) return v[15:8];
        if (s >= 2 && i == hi_pos - 1) return v[7:0];
        return 8'h00;
    endfunction

    // advances the shadow state by one item and queues the words it should produce
    task automatic pack_and_pace(input t_row r);
        int unsigned     s, c, fb, maxp;
        longint unsigned n, sum;
        logic [31:0]     v;
        logic [16:0]     mag;
        logic [7:0]      b;
        t_word           w;
        int              k;
        s    = (cfg_subslot == 0) ? 1 : (cfg_subslot > 4) ? 4 : cfg_subslot;
        c    = (cfg_channels == 0) ? 1 : (cfg_channels > 8) ? 8 : cfg_channels;
        fb   = s * c;
        maxp = (cfg_maxp > BLOCK_BYTES) ? BLOCK_BYTES : cfg_maxp;
        w    = '0;
        w.last = 1'b1;
        case (r.op)
            OP_FEEDBACK: begin
                v = (r.len >= 4) ? r.word : {6'd0, r.word[23:0], 2'b00};
                if (r.ok && r.len >= 3 && v != 0 && v < MAX_RATE) rate_q16 = v;
                w.kind       = KIND_RATE;
                w.rate_value = rate_q16;
                w.peak_level = peak_abs;
                if (r.chk == CHK_RATE) w.rate_value = r.typed_a;
                expected_words.push_back(w);
            end
            OP_PACKET: begin
                if (cfg_async) begin
                    sum      = longint'(frac_acc) + longint'(rate_q16);
                    n        = sum >> 16;
                    frac_acc = sum[15:0];
                end else begin
                    n = maxp / fb;
                end
                if (n > CAP_FRAMES) n = CAP_FRAMES;
                if (n * fb > maxp) n = maxp / fb;
                w.kind         = KIND_PACKET;
                w.rate_value   = rate_q16;
                w.frame_count  = n[8:0];
                w.packet_bytes = (n == 0) ? fb[10:0] : 11'(n * fb);
                w.peak_level   = peak_abs;
                if (r.chk == CHK_PKT) begin
                    w.frame_count  = r.typed_a[8:0];
                    w.packet_bytes = r.typed_b;
                end
                expected_words.push_back(w);
            end
            OP_SAMPLE: begin
                // most negative sample counts as full scale
                mag = r.left[15] ? (17'h10000 - {1'b0, r.left}) : {1'b0, r.left};
                if (mag > peak_abs) peak_abs = mag[15:0];
                k = 0;
                for (int ch = 0; ch < c; ch++) begin
                    for (int i = 0; i < s; i++) begin
                        b = 8'h00;
                        if (ch == 0) b = subslot_byte(s, i, r.left);
                        else if (ch == 1) b = subslot_byte(s, i, r.right);
                        w.kind       = KIND_BYTE;
                        w.rate_value = rate_q16;
                        w.byte_value = b;
                        w.peak_level = (r.chk == CHK_PEAK) ? r.typed_a[15:0] : peak_abs;
                        w.last       = (k + 1 == fb);
                        expected_words.push_back(w);
                        k++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input t_row r);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= r.op;
        in_ch.feedback_ok   <= r.ok;
        in_ch.feedback_len  <= r.len;
        in_ch.feedback_word <= r.word;
        in_ch.left_sample   <= r.left;
        in_ch.right_sample  <= r.right;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pack_and_pace(r);
        items_sent++;
    endtask

    // drop valid, let every expected word drain, then give the block time to settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_SUBSLOT:  cfg_subslot  = val[2:0];
            REG_CHANNELS: cfg_channels = val[3:0];
            REG_ASYNC:    cfg_async    = val[0];
            REG_MAXP:     cfg_maxp     = val[10:0];
            REG_SEED: begin
                cfg_seed = val[23:0];
                rate_q16 = (cfg_seed == 0) ? ZERO_SEED : {8'd0, cfg_seed};
            end
            default: ;
        endcase
        cfg_writes++;
    endtask

    function automatic logic [31:0] pick_edge(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic t_row fb_row(logic ok, logic [2:0] len, logic [31:0] word,
                                    t_check chk, logic [31:0] a);
        t_row r;
        r = '0;
        r.op = OP_FEEDBACK; r.ok = ok; r.len = len; r.word = word;
        r.chk = chk; r.typed_a = a;
        return r;
    endfunction

    function automatic t_row pkt_row(t_check chk, logic [8:0] frames, logic [10:0] nbytes);
        t_row r;
        r = '0;
        r.op = OP_PACKET; r.chk = chk; r.typed_a = {23'd0, frames}; r.typed_b = nbytes;
        return r;
    endfunction

    function automatic t_row smp_row(logic [15:0] l, logic [15:0] rt, t_check chk,
                                     logic [15:0] pk);
        t_row r;
        r = '0;
        r.op = OP_SAMPLE; r.left = l; r.right = rt; r.chk = chk; r.typed_a = {16'd0, pk};
        return r;
    endfunction

    function automatic t_row cfg_row(logic [2:0] idx, logic [31:0] val);
        t_row r;
        r = '0;
        r.kind = ROW_CFG; r.cfg_reg = idx; r.word = val;
        return r;
    endfunction

    function automatic t_row rand_row();
        t_row        r;
        int          pick;
        logic [31:0] target;
        r       = '0;
        r.ok    = 1'($urandom);
        r.len   = 3'($urandom);
        r.word  = $urandom;
        r.left  = 16'($urandom);
        r.right = 16'($urandom);
        pick    = $urandom_range(99);
        if (pick < 30) begin
            r.op = OP_FEEDBACK;
            r.ok = ($urandom_range(9) != 0);
            case ($urandom_range(7))
                0:       r.len = 3'($urandom);
                1, 2, 3: r.len = 3'd3;
                default: r.len = 3'd4;
            endcase
            target = $urandom_range(32'h0012_0000, 32'h0000_4000);
            case ($urandom_range(7))
                0:       ;
                1:       r.word = 32'd0;
                2:       r.word = MAX_RATE - $urandom_range(1);
                default: r.word = (r.len == 3) ? {r.word[31:24], target[25:2]} : target;
            endcase
        end else if (pick < 65) begin
            r.op = OP_PACKET;
        end else if (pick < 95) begin
            r.op = OP_SAMPLE;
            case ($urandom_range(5))
                0: r.left = 16'h8000;
                1: r.left = 16'h7FFF;
                2: r.right = 16'h8000;
                default: ;
            endcase
        end else begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic random_config();
        wait_idle();
        apb_write(REG_SUBSLOT, pick_edge(0, 7));
        apb_write(REG_CHANNELS, pick_edge(0, 15));
        apb_write(REG_ASYNC, ($urandom_range(2) != 0));
        apb_write(REG_MAXP, pick_edge(0, 2047));
        case ($urandom_range(5))
            0:       apb_write(REG_SEED, 32'd0);
            1:       apb_write(REG_SEED, 32'h00FF_FFFF);
            default: apb_write(REG_SEED, $urandom_range(32'h0018_0000, 32'h0000_8000));
        endcase
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : check_words
        t_word want, got;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            got = '{t_kind'(out_ch.kind), out_ch.rate_value, out_ch.frame_count,
                    out_ch.packet_bytes, out_ch.byte_value, out_ch.peak_level, out_ch.last};
            words_done++;
            if (expected_words.size() == 0) begin
                flag_error({"word with nothing expected: ", word_text(got)});
            end else begin
                want = expected_words.pop_front();
                if (got !== want)
                    flag_error({"mismatch\n  expected ", word_text(want),
                                "\n  actual   ", word_text(got)});
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= OP_FEEDBACK;
        in_ch.feedback_ok   <= 1'b0;
        in_ch.feedback_len  <= '0;
        in_ch.feedback_word <= '0;
        in_ch.left_sample   <= '0;
        in_ch.right_sample  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, starting from reset register values (rate 6.0, sync fill)
        plan.push_back(fb_row(1'b0, 3'd4, 32'h0008_0000, CHK_RATE, 32'h0006_0000));
        plan.push_back(pkt_row(CHK_PKT, 9'd256, 11'd1024));
        plan.push_back(smp_row(16'h8000, 16'h7FFF, CHK_PEAK, 16'd32768));
        plan.push_back(smp_row(16'h7FFF, 16'hFFFF, CHK_PEAK, 16'd32768));
        plan.push_back(fb_row(1'b1, 3'd2, 32'h0001_2345, CHK_RATE, 32'h0006_0000));
        plan.push_back(fb_row(1'b1, 3'd3, 32'h0002_0000, CHK_RATE, 32'h0008_0000));
        plan.push_back(fb_row(1'b1, 3'd4, 32'h0000_0000, CHK_RATE, 32'h0008_0000));
        plan.push_back(fb_row(1'b1, 3'd4, MAX_RATE, CHK_RATE, 32'h0008_0000));
        plan.push_back(fb_row(1'b1, 3'd4, 32'h00FF_FFFF, CHK_RATE, 32'h00FF_FFFF));
        plan.push_back(fb_row(1'b1, 3'd7, 32'h0004_8000, CHK_RATE, 32'h0004_8000));
        plan.push_back(fb_row(1'b1, 3'd3, 32'hFF3F_FFFF, CHK_RATE, 32'h00FF_FFFC));
        plan.push_back(fb_row(1'b1, 3'd4, 32'hFFFF_FFFF, CHK_RATE, 32'h00FF_FFFC));
        plan.push_back(fb_row(1'b1, 3'd4, 32'h0000_0001, CHK_RATE, 32'h0000_0001));
        row = '0;
        row.op = OP_UNUSED; row.ok = 1'b1; row.len = 3'd4; row.word = 32'hA5A5_5A5A;
        plan.push_back(row);
        plan.push_back(pkt_row(CHK_PKT, 9'd256, 11'd1024));
        plan.push_back(fb_row(1'b1, 3'd4, 32'h0002_8000, CHK_RATE, 32'h0002_8000));
        plan.push_back(cfg_row(REG_ASYNC, 32'd1));
        plan.push_back(pkt_row(CHK_PKT, 9'd2, 11'd8));
        plan.push_back(pkt_row(CHK_PKT, 9'd3, 11'd12));
        plan.push_back(cfg_row(REG_SEED, 32'd0));
        plan.push_back(fb_row(1'b0, 3'd0, 32'd0, CHK_RATE, 32'h0006_0000));
        plan.push_back(cfg_row(REG_SEED, 32'h0000_0100));
        plan.push_back(pkt_row(CHK_PKT, 9'd0, 11'd4));
        plan.push_back(cfg_row(REG_SUBSLOT, 32'd0));
        plan.push_back(cfg_row(REG_CHANNELS, 32'd0));
        plan.push_back(smp_row(16'h1234, 16'h5678, CHK_NONE, 16'd0));
        plan.push_back(cfg_row(REG_SUBSLOT, 32'd7));
        plan.push_back(cfg_row(REG_CHANNELS, 32'd15));
        plan.push_back(smp_row(16'hFFFE, 16'h7FFF, CHK_NONE, 16'd0));
        plan.push_back(cfg_row(REG_SEED, 32'h00FF_FFFF));
        plan.push_back(cfg_row(REG_MAXP, 32'd2047));
        plan.push_back(pkt_row(CHK_PKT, 9'd32, 11'd1024));
        plan.push_back(cfg_row(REG_ASYNC, 32'd0));
        plan.push_back(cfg_row(REG_MAXP, 32'd0));
        plan.push_back(pkt_row(CHK_PKT, 9'd0, 11'd32));
        plan.push_back(cfg_row(REG_SUBSLOT, 32'd3));
        plan.push_back(cfg_row(REG_CHANNELS, 32'd2));
        plan.push_back(cfg_row(REG_MAXP, 32'd1));
        plan.push_back(pkt_row(CHK_PKT, 9'd0, 11'd6));
        plan.push_back(smp_row(16'h8001, 16'h0100, CHK_NONE, 16'd0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                apb_write(plan[i].cfg_reg, plan[i].word);
            end else begin
                send_item(plan[i]);
            end
        end

        // random part: three idle schedules, new register settings per segment
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin tx_idle_pct = 6;  rx_idle_pct = 66; end
                1: begin tx_idle_pct = 66; rx_idle_pct = 6;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            random_config();
            counted = 0;
            while (counted < SEG_ITEMS) begin
                if (seg == 4 && counted == 20) wait_idle();  // full drain mid-stream
                row = rand_row();
                send_item(row);
                if (row.op != OP_UNUSED) counted++;
            end
        end

        wait_idle();
        if (expected_words.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", expected_words.size()));
        $display("Ran %0d items (%0d directed rows) and %0d register writes; %0d words checked",
                 items_sent, plan.size(), cfg_writes, words_done);
        $display("Covered feedback, packet sizing and sample packing under three idle mixes");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors", err_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/aaop_pkg.sv
sv/aaop_if.sv
sv/aaop_cfg.sv
sv/aaop_div.sv
sv/aaop_ctrl.sv
sv/aaop_dp.sv
sv/async_audio_out_packetizer.sv
tb/testbench.sv
